/* hw/rtl/hcbd_pkg.sv */
package hcbd_pkg;

   localparam int SIZE_BITS_DEF  = 32;
   localparam int LINE_LIMIT_DEF = 31;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // One result word handed from the parser to the output stage.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       kind;
   } result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.is_hex = 1'b1;
      r.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.value = c[3:0] + 4'd9;
      end else begin
         r.is_hex = 1'b0;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/hcbd_parser.sv */
module hcbd_parser
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS  = SIZE_BITS_DEF,
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       chunked_enable,
   output result_type result
);

   localparam int LEN_BITS = $clog2(LINE_LIMIT + 1);
   localparam logic [LEN_BITS-1:0] LINE_LIMIT_L = LEN_BITS'(LINE_LIMIT);

   logic                 data_phase_ff, data_phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic [SIZE_BITS-1:0] accum_ff, accum_in;
   logic                 hex_open_ff, hex_open_in;
   logic [LEN_BITS-1:0]  line_len_ff, line_len_in;
   logic                 first_cr_ff, first_cr_in;

   hex_digit_type        digit;
   logic [LEN_BITS-1:0]  len_inc;
   logic [SIZE_BITS-1:0] remaining_dec;
   logic                 line_done;
   logic                 line_empty;
   logic [SIZE_BITS-1:0] line_size;

   assign digit         = hex_decode(in_byte);
   assign len_inc       = line_len_ff + 1'b1;
   assign remaining_dec = remaining_ff - 1'b1;

   always_comb begin
      data_phase_in = data_phase_ff;
      remaining_in  = remaining_ff;
      accum_in      = accum_ff;
      hex_open_in   = hex_open_ff;
      line_len_in   = line_len_ff;
      first_cr_in   = first_cr_ff;
      result.valid  = 1'b0;
      result.data   = in_byte;
      result.kind   = KIND_PAYLOAD;
      line_done     = 1'b0;
      line_empty    = 1'b0;
      line_size     = '0;

      if (step) begin
         if (!chunked_enable) begin
            result.valid = 1'b1;
         end else if (data_phase_ff) begin
            result.valid = 1'b1;
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               data_phase_in = 1'b0;
               accum_in      = '0;
               hex_open_in   = 1'b1;
               line_len_in   = '0;
               first_cr_in   = 1'b0;
            end
         end else if (in_byte == CHAR_LF) begin
            line_done  = 1'b1;
            line_empty = (line_len_ff == '0) ||
                         (line_len_ff == LEN_BITS'(1) && first_cr_ff);
            line_size  = accum_ff;
         end else begin
            if (line_len_ff == '0) begin
               first_cr_in = (in_byte == CHAR_CR);
            end
            if (hex_open_ff) begin
               if (!digit.is_hex) begin
                  hex_open_in = 1'b0;
               end else if (accum_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                  // Saturate once another digit would shift bits out.
                  accum_in = '1;
               end else begin
                  accum_in = {accum_ff[SIZE_BITS-5:0], digit.value};
               end
            end
            line_len_in = len_inc;
            if (len_inc >= LINE_LIMIT_L) begin
               line_done  = 1'b1;
               line_size  = accum_in;
               // A line cut at the limit has characters, so it is never empty.
               line_empty = 1'b0;
            end
         end

         if (line_done) begin
            accum_in    = '0;
            hex_open_in = 1'b1;
            line_len_in = '0;
            first_cr_in = 1'b0;
            if (!line_empty) begin
               if (line_size == '0) begin
                  result.valid = 1'b1;
                  result.data  = 8'd0;
                  result.kind  = KIND_END;
               end else begin
                  remaining_in  = line_size;
                  data_phase_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_phase_ff <= 1'b0;
         remaining_ff  <= '0;
         accum_ff      <= '0;
         hex_open_ff   <= 1'b1;
         line_len_ff   <= '0;
         first_cr_ff   <= 1'b0;
      end else begin
         data_phase_ff <= data_phase_in;
         remaining_ff  <= remaining_in;
         accum_ff      <= accum_in;
         hex_open_ff   <= hex_open_in;
         line_len_ff   <= line_len_in;
         first_cr_ff   <= first_cr_in;
      end
   end

endmodule

/* hw/rtl/hcbd_out_stage.sv */
module hcbd_out_stage
   import hcbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       can_load,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       kind_ff, kind_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      kind_in  = kind_ff;
      if (can_load) begin
         valid_in = result.valid;
         data_in  = result.data;
         kind_in  = result.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

endmodule

/* hw/rtl/http_chunked_body_decoder_top.sv */
// Chunked HTTP body decoder.
// req_* carries one body byte per word. rsp_* returns payload bytes with
// tuser 0, and a single end-of-body word (tdata 0, tuser 1) when a size
// line of value zero is parsed. Size lines and the CR LF after each chunk
// produce no word at all.
// csr_wr_en / csr_wr_data set chunked_enable: 1 decodes chunked framing,
// 0 passes every byte through unchanged. Write it only while idle.
// Throughput is one byte per cycle while rsp_tready stays high. A byte is
// held in the input register, parsed there against the framing state, and
// its result lands in the output register, which drives rsp_tvalid. The
// parse step is a hex decode, a shift with saturation and a line counter
// compare.
// Reset (synchronous) returns to the start of a size line with an empty
// pipeline and chunked_enable at 1.
// When rsp_tready is low the output register holds its word; the input
// register still accepts one more byte, then req_tready drops until the
// output drains.
module http_chunked_body_decoder_top
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS  = SIZE_BITS_DEF,
   parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] kind
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic       enable_ff, enable_in;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_take;
   logic       can_load;
   result_type result;

   assign s1_take    = s1_valid_ff && can_load;
   assign req_tready = !s1_valid_ff || can_load;

   always_comb begin
      enable_in   = csr_wr_en ? csr_wr_data : enable_ff;
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         enable_ff   <= enable_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
   end

   hcbd_parser #(
      .SIZE_BITS  (SIZE_BITS),
      .LINE_LIMIT (LINE_LIMIT)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (s1_take),
      .in_byte        (s1_byte_ff),
      .chunked_enable (enable_ff),
      .result         (result)
   );

   hcbd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // An end-of-body word always carries a zero data byte.
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_END |-> rsp_tdata == 8'd0)
      else $error("end-of-body word with nonzero data");

   // In passthrough every parsed byte becomes a payload word.
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      s1_take && !enable_ff |=> rsp_tvalid && rsp_tuser == KIND_PAYLOAD
                                && rsp_tdata == $past(s1_byte_ff))
      else $error("passthrough byte lost or altered");

   // An empty input register must always take a word.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stalled with empty input register");

endmodule

/* tb/sv/http_chunked_body_decoder_top_tb.sv */
`timescale 1ns / 100ps

module http_chunked_body_decoder_top_tb;
   import hcbd_pkg::*;

   localparam int SZ = SIZE_BITS_DEF;
   localparam logic [SZ-1:0] SIZE_CAP = '1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int REPORT_LIMIT = 100;
   localparam int DIR_ROWS = 27;

   typedef struct packed {
      logic [7:0] data;
      logic       kind;
   } rsp_word_type;

   // One row of the directed table: either a mode write or one input byte,
   // with an optional hand-written result.
   typedef struct packed {
      logic       is_cfg;
      logic [7:0] value;
      logic       typed;
      logic       yields;
      logic [7:0] data;
      logic       kind;
   } vec_row_type;

   function automatic vec_row_type byte_row(input logic [7:0] b);
      return {1'b0, b, 1'b0, 1'b0, 8'h00, KIND_PAYLOAD};
   endfunction

   function automatic vec_row_type quiet_row(input logic [7:0] b);
      return {1'b0, b, 1'b1, 1'b0, 8'h00, KIND_PAYLOAD};
   endfunction

   function automatic vec_row_type payload_row(input logic [7:0] b);
      return {1'b0, b, 1'b1, 1'b1, b, KIND_PAYLOAD};
   endfunction

   function automatic vec_row_type end_row(input logic [7:0] b);
      return {1'b0, b, 1'b1, 1'b1, 8'h00, KIND_END};
   endfunction

   function automatic vec_row_type mode_row(input logic v);
      return {1'b1, 7'd0, v, 1'b0, 1'b0, 8'h00, KIND_PAYLOAD};
   endfunction

   localparam vec_row_type DIR_TABLE [DIR_ROWS] = '{
      quiet_row("0"), quiet_row(CHAR_CR), end_row(CHAR_LF),
      quiet_row(CHAR_CR), quiet_row(CHAR_LF),
      byte_row("2"), byte_row(";"), byte_row(CHAR_LF),
      payload_row(8'hFF), payload_row(8'h00),
      byte_row(8'h00), byte_row(CHAR_LF),
      byte_row("0"), byte_row("x"), byte_row("1"), byte_row(CHAR_LF),
      byte_row("1"), byte_row(CHAR_LF), byte_row(CHAR_LF),
      mode_row(1'b0),
      payload_row(CHAR_LF), payload_row("5"), payload_row(8'hFF),
      mode_row(1'b1),
      byte_row(CHAR_CR), byte_row(CHAR_CR), byte_row(CHAR_LF)
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   http_chunked_body_decoder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Decoder state as the testbench sees it.
   logic          chunk_on;
   logic          in_body;
   logic [SZ-1:0] bytes_owed;
   logic [SZ-1:0] size_val;
   logic          digits_open;
   int unsigned   line_len;
   logic          cr_first;

   rsp_word_type pending_words[$];
   rsp_word_type want;
   int unsigned  errors = 0;
   int unsigned  cycles = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  sink_hold = 0;
   bit           calm = 1'b0;

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return int'(c) - 48;
      end else if (c >= "a" && c <= "f") begin
         return int'(c) - 87;
      end else if (c >= "A" && c <= "F") begin
         return int'(c) - 55;
      end
      return -1;
   endfunction

   task automatic start_line();
      size_val = '0;
      digits_open = 1'b1;
      line_len = 0;
      cr_first = 1'b0;
   endtask

   task automatic close_line(output bit emits, output rsp_word_type w);
      bit            blank;
      logic [SZ-1:0] v;
      blank = line_len == 0 || (line_len == 1 && cr_first);
      v = size_val;
      start_line();
      emits = 1'b0;
      w = {8'h00, KIND_END};
      if (!blank) begin
         if (v == 0) begin
            emits = 1'b1;
         end else begin
            bytes_owed = v;
            in_body = 1'b1;
         end
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, output bit emits, output rsp_word_type w);
      int digit;
      emits = 1'b0;
      w = {b, KIND_PAYLOAD};
      if (!chunk_on || in_body) begin
         emits = 1'b1;
         if (chunk_on) begin
            bytes_owed = bytes_owed - 1'b1;
            if (bytes_owed == 0) begin
               in_body = 1'b0;
               start_line();
            end
         end
      end else if (b == CHAR_LF) begin
         close_line(emits, w);
      end else begin
         if (line_len == 0) begin
            cr_first = (b == CHAR_CR);
         end
         if (digits_open) begin
            digit = nibble_of(b);
            if (digit < 0) begin
               digits_open = 1'b0;
            end else if (size_val > (SIZE_CAP >> 4)) begin
               size_val = SIZE_CAP;
            end else begin
               size_val = {size_val[SZ-5:0], 4'(digit)};
            end
         end
         line_len++;
         if (line_len >= LINE_LIMIT_DEF) begin
            close_line(emits, w);
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input bit yields,
                            input rsp_word_type w);
      bit           emits;
      rsp_word_type pred;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      decode_byte(b, emits, pred);
      if (typed) begin
         emits = yields;
         pred = w;
      end
      if (emits) begin
         pending_words.push_back(pred);
      end
      bytes_sent++;
   endtask

   task automatic put(input logic [7:0] b);
      send_byte(b, 1'b0, 1'b0, '0);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      // Size-line bytes leave no word behind, so give the pipeline time to empty.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      chunk_on = v;
   endtask

   function automatic logic [7:0] filler_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF || nibble_of(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) begin
         return 8'h30 + nib;
      end
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
   endfunction

   task automatic send_hex(input int unsigned v);
      int top;
      top = 0;
      for (int i = 0; i < 8; i++) begin
         if ((v >> (4 * i)) != 0) top = i;
      end
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) put("0");
      for (int i = top; i >= 0; i--) begin
         put(hex_char(4'(v >> (4 * i))));
      end
   endtask

   task automatic send_crlf();
      if ($urandom_range(0, 7) != 0) put(CHAR_CR);
      put(CHAR_LF);
   endtask

   task automatic send_segment();
      int unsigned pick;
      int unsigned n;
      int unsigned n_sent;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         // A chunk, now and then with a body one byte short or one too long.
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
         send_hex(n);
         if ($urandom_range(0, 3) == 0) begin
            put(";");
            repeat ($urandom_range(0, 4)) put(filler_char());
         end
         send_crlf();
         n_sent = n;
         if ($urandom_range(0, 19) == 0) begin
            n_sent = n - 1;
         end else if ($urandom_range(0, 19) == 0) begin
            n_sent = n + 1;
         end
         for (int i = 0; i < n_sent; i++) begin
            put(i < n ? 8'($urandom_range(0, 255)) : filler_char());
         end
         send_crlf();
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 3)) put("0");
         send_crlf();
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 6)) put(filler_char());
            send_crlf();
         end
         send_crlf();
      end else if (pick < 80) begin
         // A line that runs past the length limit without an LF in time.
         len = $urandom_range(31, 40);
         if ($urandom_range(0, 1) == 0) begin
            put(hex_char(4'($urandom_range(1, 15))));
            len--;
         end
         repeat (len) put(filler_char());
         put(CHAR_LF);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0: begin
                  put(CHAR_LF);
               end
               1: begin
                  put(CHAR_CR);
                  put(CHAR_LF);
               end
               default: begin
                  put(CHAR_CR);
                  put(CHAR_CR);
                  put(CHAR_LF);
               end
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 6)) put(filler_char());
         if ($urandom_range(0, 1) == 0) put(CHAR_LF);
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: unexpected word, expected none, got tdata %02h tuser %0b",
                        $time, rsp_tdata, rsp_tuser);
            end
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser !== want.kind) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: mismatch, expected tdata %02h tuser %0b, got tdata %02h tuser %0b",
                           $time, want.data, want.kind, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         sink_hold = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL http_chunked_body_decoder_top");
         $finish;
      end
   end

   initial begin : stimulus
      vec_row_type row;
      int unsigned phase_end;
      chunk_on = 1'b1;
      in_body = 1'b0;
      bytes_owed = '0;
      start_line();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIR_TABLE[r];
         if (row.is_cfg) begin
            write_mode(row.value[0]);
         end else begin
            send_byte(row.value, row.typed, row.yields, {row.data, row.kind});
         end
      end

      // Mostly chunked phases, with passthrough phases in between.
      for (int ph = 0; ph < 10; ph++) begin
         write_mode(ph % 4 != 3);
         if (ph == 9) calm = 1'b1;
         phase_end = bytes_sent + 200;
         while (bytes_sent < phase_end) begin
            if (chunk_on) begin
               send_segment();
            end else begin
               put(8'($urandom_range(0, 255)));
            end
         end
      end

      // A size line long enough to saturate; the body then never ends.
      put("1");
      repeat (9) put(hex_char(4'($urandom_range(0, 15))));
      put(CHAR_CR);
      put(CHAR_LF);
      repeat (40) put(8'($urandom_range(0, 255)));

      settle();
      if (errors == 0) begin
         $display("PASS http_chunked_body_decoder_top");
      end else begin
         $display("FAIL http_chunked_body_decoder_top");
      end
      $finish;
   end

endmodule
